### rtl/core/assert_macros.svh
// Assertion macros shared by the sampler RTL.
// Depends on nothing; included inside module bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check a condition in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/core/kccs_pkg.sv
// Types and constants for the keyframe color curve sampler.
// No dependencies.
package kccs_pkg;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_SAMPLE  = 2'd2;

  localparam logic REG_KEYS_IN_USE = 1'b0;
  localparam logic REG_GLOBAL_GAIN = 1'b1;
  localparam int   CFG_IDX_BITS    = 1;
  localparam int   CFG_DATA_BITS   = 16;

  localparam logic [15:0] GAIN_RESET = 16'd256;
  localparam int   FIELD_TIME_BITS = 32;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  key_index;
    logic [31:0] key_time;
    logic [15:0] key_red;
    logic [15:0] key_green;
    logic [15:0] key_blue;
    logic [15:0] key_alpha;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic        time_fault;
  } out_item_t;

endpackage

### rtl/core/kccs_front.sv
// Front end: accepts items, performs loads and restarts, queues samples.
// Depends on kccs_pkg.
module kccs_front #(
  parameter int MaxKeys  = 16,
  parameter int TimeBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  kccs_pkg::in_item_t  in_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  // back end is working on a sample
  input  logic                back_busy_i,
  // key table write port to back end
  output logic                kwr_en_o,
  output logic [$clog2(MaxKeys)-1:0] kwr_idx_o,
  output logic [TimeBits-1:0] kwr_time_o,
  output logic [63:0]         kwr_val_o,
  // sample queue toward back end
  output logic                q_valid_o,
  input  logic                q_pop_i,
  output logic [TimeBits-1:0] q_elapsed_o
);
  import kccs_pkg::*;

  localparam int IdxBits = $clog2(MaxKeys);
  localparam int QDepth  = 2;

  logic [TimeBits-1:0] start_q, start_d;
  logic [TimeBits-1:0] qmem_q [QDepth];
  logic                wp_q, rp_q;
  logic [1:0]          cnt_q;
  logic                acc, push;
  logic [TimeBits-1:0] now_t, slot_t;

  assign now_t  = TimeBits'(in_i.now_time);
  assign slot_t = TimeBits'(in_i.key_time);
  // hold a load until every earlier sample has left the back end
  assign in_stall_o = (cnt_q == 2'(QDepth)) ||
                      ((in_i.cmd == CMD_LOAD) && ((cnt_q != 2'd0) || back_busy_i));
  assign acc  = in_valid_i && !in_stall_o;
  assign push = acc && (in_i.cmd == CMD_SAMPLE);

  // write key table on load; slots beyond the table are dropped
  assign kwr_en_o   = acc && (in_i.cmd == CMD_LOAD) && (32'(in_i.key_index) < MaxKeys);
  assign kwr_idx_o  = IdxBits'(in_i.key_index);
  assign kwr_time_o = slot_t;
  assign kwr_val_o  = {in_i.key_alpha, in_i.key_blue, in_i.key_green, in_i.key_red};

  always_comb begin
    start_d = start_q;
    if (acc && in_i.cmd == CMD_RESTART) start_d = now_t;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      wp_q    <= 1'b0;
      rp_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      start_q <= start_d;
      if (push) wp_q <= ~wp_q;
      if (q_pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end

  // queue holds elapsed time of each pending sample
  always_ff @(posedge clk_i) begin
    if (push) qmem_q[wp_q] <= now_t - start_q;
  end

  assign q_valid_o   = (cnt_q != 2'd0);
  assign q_elapsed_o = qmem_q[rp_q];

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_pop_empty, clk_i, rst_ni, q_pop_i, cnt_q != 2'd0)
  `ASSERT_IMPL(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= 2'(QDepth))
  `ASSERT_NEXT(a_restart_latch, clk_i, rst_ni, acc && in_i.cmd == CMD_RESTART,
    start_q == $past(now_t))
endmodule

### rtl/core/kccs_back.sv
// Back end: wrap, key search, division and gain for queued samples.
// Depends on kccs_pkg.
module kccs_back #(
  parameter int MaxKeys  = 16,
  parameter int TimeBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [4:0]          keys_in_use_i,
  input  logic [15:0]         gain_i,
  input  logic                kwr_en_i,
  input  logic [$clog2(MaxKeys)-1:0] kwr_idx_i,
  input  logic [TimeBits-1:0] kwr_time_i,
  input  logic [63:0]         kwr_val_i,
  input  logic                q_valid_i,
  output logic                q_pop_o,
  input  logic [TimeBits-1:0] q_elapsed_i,
  output logic                busy_o,
  output kccs_pkg::out_item_t out_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);
  import kccs_pkg::*;

  localparam int IdxBits = $clog2(MaxKeys);
  localparam int CntBits = IdxBits + 1;
  localparam int TbCnt   = $clog2(TimeBits + 1);
  localparam int NumW    = TimeBits + 17;
  localparam int DcW     = $clog2(NumW + 1);

  localparam logic [3:0] S_IDLE = 4'd0, S_LAST = 4'd1, S_WRAP = 4'd2, S_SRCH = 4'd3,
    S_PREV = 4'd4, S_SETUP = 4'd5, S_MULA = 4'd6, S_MULB = 4'd7, S_DIV = 4'd8,
    S_GAIN = 4'd9, S_OUT = 4'd10;

  // key memories, one read port each, registered reads
  logic [TimeBits-1:0] tmem [MaxKeys];
  logic [63:0]         vmem [MaxKeys];
  logic [IdxBits-1:0]  raddr;
  logic [TimeBits-1:0] trd_q;
  logic [63:0]         vrd_q;

  always_ff @(posedge clk_i) begin
    if (kwr_en_i) begin
      tmem[kwr_idx_i] <= kwr_time_i;
      vmem[kwr_idx_i] <= kwr_val_i;
    end
    trd_q <= tmem[raddr];
    vrd_q <= vmem[raddr];
  end

  logic [3:0]          st_q;
  logic [CntBits-1:0]  n_q, i_q;
  logic [TimeBits-1:0] el_q, last_q, next_q, rem_q;
  logic [TbCnt-1:0]    bit_q;
  logic [63:0]         bv_q, av_q;
  logic                fault_q, zero_q, pend_q;
  logic [1:0]          ch_q;
  logic [TimeBits-1:0] num_q, den_q;
  logic [NumW-1:0]     acc_q, prodv_q;
  logic [NumW-1:0]     dq_q;
  logic [TimeBits:0]   drem_q;
  logic [DcW-1:0]      dcnt_q;
  logic [15:0]         col_q [4];
  logic [31:0]         sc_q;
  out_item_t           res_q;
  logic                ovld_q;

  logic [CntBits-1:0]  nsat;
  logic [TimeBits:0]   rtry;
  logic [TimeBits:0]   dtry;
  logic [15:0]         achan, bchan;
  logic [TimeBits:0]   wr_sh;

  assign nsat = (32'(keys_in_use_i) > MaxKeys) ? CntBits'(MaxKeys) : CntBits'(keys_in_use_i);
  assign achan = av_q[16*ch_q +: 16];
  assign bchan = bv_q[16*ch_q +: 16];
  assign q_pop_o = (st_q == S_IDLE) && q_valid_i && !pend_q;
  assign busy_o = (st_q != S_IDLE);
  assign out_valid_o = ovld_q;
  assign out_o = res_q;

  always_comb begin
    raddr = IdxBits'(i_q);
    if (st_q == S_IDLE) raddr = IdxBits'(nsat - CntBits'(1));
  end

  // restoring modulo step: one quotient bit per cycle
  assign wr_sh = {rem_q, el_q[TimeBits-1]};
  assign rtry  = wr_sh - {1'b0, last_q};
  assign dtry  = {drem_q[TimeBits-1:0], dq_q[NumW-1]} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      ovld_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      if (ovld_q && !out_stall_i) ovld_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          pend_q <= 1'b0;
          if (q_valid_i && !pend_q) begin
            n_q <= nsat;
            el_q <= q_elapsed_i;
            fault_q <= 1'b0;
            zero_q <= 1'b1;
            st_q <= (nsat == '0) ? S_IDLE : S_LAST;
          end
        end
        S_LAST: begin
          last_q <= trd_q;
          rem_q  <= '0;
          bit_q  <= TbCnt'(TimeBits);
          i_q    <= CntBits'(1);
          if (el_q > trd_q) begin
            if (trd_q == '0) begin
              fault_q <= 1'b1;
              st_q <= S_SETUP;
            end else st_q <= S_WRAP;
          end else st_q <= S_SRCH;
        end
        S_WRAP: begin
          // shift dividend bits through el_q, remainder builds in rem_q
          el_q <= el_q << 1;
          if (!rtry[TimeBits]) rem_q <= rtry[TimeBits-1:0];
          else rem_q <= wr_sh[TimeBits-1:0];
          bit_q <= bit_q - TbCnt'(1);
          if (bit_q == TbCnt'(1)) begin
            st_q <= S_PREV;
            i_q  <= '0;
          end
        end
        S_PREV: begin
          // load wrapped value back into el_q after modulo
          el_q <= rem_q;
          i_q  <= CntBits'(1);
          st_q <= S_SRCH;
        end
        S_SRCH: begin
          // wait for the registered read of key i, then compare
          if (pend_q) begin
            pend_q <= 1'b0;
            if (el_q < trd_q) begin
              next_q <= trd_q;
              bv_q <= vrd_q;
              zero_q <= 1'b0;
              i_q <= i_q - CntBits'(1);
              st_q <= S_SETUP;
              dcnt_q <= '0;
            end else if (i_q + CntBits'(1) >= n_q) begin
              st_q <= S_SETUP;
            end else i_q <= i_q + CntBits'(1);
          end else if (i_q >= n_q) st_q <= S_SETUP;
          else pend_q <= 1'b1;
        end
        S_SETUP: begin
          // fetch previous key (the key read is registered)
          if (!zero_q && dcnt_q == '0) dcnt_q <= DcW'(1);
          else if (!zero_q && dcnt_q == DcW'(1)) dcnt_q <= DcW'(2);
          else begin
            if (!zero_q) begin
              av_q <= vrd_q;
              if (el_q >= trd_q) begin
                num_q <= el_q - trd_q;
                den_q <= next_q - trd_q;
              end else begin
                num_q <= '0;
                den_q <= TimeBits'(1);
              end
            end
            ch_q <= 2'd0;
            st_q <= zero_q || fault_q ? S_GAIN : S_MULA;
            if (zero_q || fault_q) begin
              for (int k = 0; k < 4; k++) col_q[k] <= '0;
            end
          end
        end
        S_MULA: begin
          acc_q <= NumW'(achan) * NumW'(den_q - num_q);
          prodv_q <= NumW'(bchan) * NumW'(num_q);
          st_q <= S_MULB;
        end
        S_MULB: begin
          dq_q <= acc_q + prodv_q;
          drem_q <= '0;
          dcnt_q <= DcW'(NumW);
          st_q <= S_DIV;
        end
        S_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (!dtry[TimeBits]) begin
            drem_q <= dtry;
            dq_q <= {dq_q[NumW-2:0], 1'b1};
          end else begin
            drem_q <= {drem_q[TimeBits-1:0], dq_q[NumW-1]};
            dq_q <= {dq_q[NumW-2:0], 1'b0};
          end
          dcnt_q <= dcnt_q - DcW'(1);
          if (dcnt_q == DcW'(1)) begin
            st_q <= S_GAIN;
          end
        end
        S_GAIN: begin
          // store quotient of finished channel, advance
          if (!(zero_q || fault_q)) begin
            col_q[ch_q] <= dq_q[15:0];
          end
          if (zero_q || fault_q || ch_q == 2'd3) begin
            ch_q <= 2'd0;
            st_q <= S_OUT;
            dcnt_q <= '0;
          end else begin
            ch_q <= ch_q + 2'd1;
            st_q <= S_MULA;
          end
        end
        S_OUT: begin
          // wait for the previous result to leave, scale one channel per cycle, then publish
          if (!ovld_q) begin
            if (dcnt_q[2:0] < 3'd4) begin
              sc_q <= 32'(col_q[dcnt_q[1:0]]) * 32'(gain_i);
              dcnt_q <= dcnt_q + DcW'(1);
              if (dcnt_q != '0) begin
                case (dcnt_q[1:0])
                  2'd1: res_q.out_red   <= (|sc_q[31:24]) ? 16'hFFFF : sc_q[23:8];
                  2'd2: res_q.out_green <= (|sc_q[31:24]) ? 16'hFFFF : sc_q[23:8];
                  2'd3: res_q.out_blue  <= (|sc_q[31:24]) ? 16'hFFFF : sc_q[23:8];
                  default: res_q.out_red <= res_q.out_red;
                endcase
              end
            end else begin
              res_q.out_alpha  <= (|sc_q[31:24]) ? 16'hFFFF : sc_q[23:8];
              res_q.time_fault <= fault_q;
              ovld_q <= 1'b1;
              pend_q <= 1'b1;
              st_q <= S_IDLE;
            end
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_pop_idle, clk_i, rst_ni, q_pop_o, st_q == S_IDLE)
  `ASSERT_IMPL(a_out_hold, clk_i, rst_ni, ovld_q && out_stall_i, st_q != S_OUT || !(dcnt_q[2:0] >= 3'd4))
  `ASSERT_IMPL(a_fault_zero, clk_i, rst_ni, ovld_q && res_q.time_fault,
    res_q.out_red == 16'd0 && res_q.out_alpha == 16'd0)
endmodule

### rtl/core/keyframe_color_curve_sampler_core.sv
// Top level of the keyframe color curve sampler: config registers, front, back.
// Depends on kccs_pkg, kccs_front, kccs_back.
//
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i/in_stall_o   | kccs_pkg::in_item_t
//  out     | output    | out_valid_o/out_stall_i | kccs_pkg::out_item_t
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// Loads and restarts complete in the front end; a load waits while any
// sample is queued or running so the key table never changes under it.
// In the back end a sample's time is set mostly by the bit-serial modulo and
// the bit-serial per-channel divider, and a stalled pending result holds it
// further.
// A two-entry queue lets the front keep accepting while a sample runs.
// Reset clears control state; key memory is undefined until loaded.
module keyframe_color_curve_sampler_core #(
  parameter int MaxKeys  = 16,
  parameter int TimeBits = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [kccs_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [kccs_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  kccs_pkg::in_item_t  in_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output kccs_pkg::out_item_t out_o,
  output logic                out_valid_o,
  input  logic                out_stall_i
);
  import kccs_pkg::*;

  localparam int IdxBits = $clog2(MaxKeys);

  logic [4:0]  keys_q;
  logic [15:0] gain_q;
  logic                kwr_en;
  logic [IdxBits-1:0]  kwr_idx;
  logic [TimeBits-1:0] kwr_time, q_el;
  logic [63:0]         kwr_val;
  logic                q_valid, q_pop;
  logic                back_busy;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keys_q <= '0;
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_KEYS_IN_USE) keys_q <= cfg_data_i[4:0];
      else gain_q <= cfg_data_i;
    end
  end

  kccs_front #(.MaxKeys(MaxKeys), .TimeBits(TimeBits)) u_front (
    .clk_i, .rst_ni, .in_i, .in_valid_i, .in_stall_o, .back_busy_i(back_busy),
    .kwr_en_o(kwr_en), .kwr_idx_o(kwr_idx), .kwr_time_o(kwr_time), .kwr_val_o(kwr_val),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_elapsed_o(q_el)
  );

  kccs_back #(.MaxKeys(MaxKeys), .TimeBits(TimeBits)) u_back (
    .clk_i, .rst_ni, .keys_in_use_i(keys_q), .gain_i(gain_q),
    .kwr_en_i(kwr_en), .kwr_idx_i(kwr_idx), .kwr_time_i(kwr_time), .kwr_val_i(kwr_val),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_elapsed_i(q_el), .busy_o(back_busy),
    .out_o, .out_valid_o, .out_stall_i
  );
endmodule

### tb/sv/keyframe_color_curve_sampler_core_tb.sv
// Self-checking testbench for keyframe_color_curve_sampler_core: directed table, then random
// phases checked against a behavioral curve predictor. Depends on kccs_pkg and the core RTL.
module keyframe_color_curve_sampler_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kccs_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 400;
  localparam int STALL_LIMIT  = 20000;
  localparam int HOLD_CYCLES  = 1500;
  localparam int NUM_PHASES   = 8;
  localparam int PHASE_ITEMS  = 225;

  typedef struct {
    bit        typed;
    bit        want_res;
    out_item_t want;
  } row_tag_t;

  typedef struct {
    bit        is_cfg;
    logic [4:0]  keys;
    logic [15:0] gain;
    in_item_t  item;
    row_tag_t  tag;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx_i = REG_KEYS_IN_USE;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;
  in_item_t in_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  out_item_t out_o;
  logic out_valid_o;
  logic out_stall_i = 1'b0;

  keyframe_color_curve_sampler_core u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_i, .in_valid_i, .in_stall_o, .out_o, .out_valid_o, .out_stall_i
  );

  always #5 clk_i = ~clk_i;

  // Predictor state: key table, animation start and register copies
  logic [31:0] curve_time [16];
  logic [15:0] curve_chan [16][4];
  logic [31:0] anchor_time = '0;
  int unsigned key_count = 0;
  logic [15:0] gain_now = GAIN_RESET;

  out_item_t pending_colors[$];
  row_tag_t  row_tags[$];
  plan_row_t plan[$];
  int miss_count = 0;
  int idle_cycles = 0;
  int tx_pct = 0;
  int rx_pct = 0;
  bit hold_ask = 0;
  bit hold_done = 0;
  int held = 0;

  // Stimulus-side view of the table, used to aim samples
  logic [31:0] g_time [16];
  logic [31:0] g_start = '0;
  int unsigned g_keys = 0;
  int unsigned g_max = 64;

  function automatic in_item_t mk_item(logic [1:0] cmd, logic [3:0] idx, logic [31:0] t,
                                       logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                       logic [15:0] a, logic [31:0] now);
    in_item_t it;
    it.cmd = cmd; it.key_index = idx; it.key_time = t;
    it.key_red = r; it.key_green = g; it.key_blue = b; it.key_alpha = a;
    it.now_time = now;
    return it;
  endfunction

  function automatic out_item_t mk_color(logic [15:0] r, logic [15:0] g, logic [15:0] b,
                                         logic [15:0] a, logic f);
    out_item_t o;
    o.out_red = r; o.out_green = g; o.out_blue = b; o.out_alpha = a; o.time_fault = f;
    return o;
  endfunction

  function automatic void add_item(in_item_t it);
    plan_row_t row;
    row = '{default: '0};
    row.item = it;
    plan.push_back(row);
  endfunction

  function automatic void add_typed(in_item_t it, bit res, out_item_t want);
    plan_row_t row;
    row = '{default: '0};
    row.item = it;
    row.tag = '{typed: 1'b1, want_res: res, want: want};
    plan.push_back(row);
  endfunction

  function automatic void add_cfg(logic [4:0] keys, logic [15:0] gain);
    plan_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1; row.keys = keys; row.gain = gain;
    plan.push_back(row);
  endfunction

  // Advance the predictor by one transaction; return 1 when it yields a color
  function automatic bit curve_step(input in_item_t it, output out_item_t res);
    logic [31:0] elapsed, last, prev, nxt;
    longint unsigned num, den, a, b, s;
    longint unsigned col [4];
    int n;
    bit fault, found;
    res = '0;
    fault = 0;
    found = 0;
    col = '{default: 0};
    case (it.cmd)
      CMD_LOAD: begin
        curve_time[it.key_index] = it.key_time;
        curve_chan[it.key_index] = '{it.key_red, it.key_green, it.key_blue, it.key_alpha};
        return 0;
      end
      CMD_RESTART: begin
        anchor_time = it.now_time;
        return 0;
      end
      CMD_SAMPLE: begin
        n = (key_count > 16) ? 16 : key_count;
        if (n == 0) return 0;
        elapsed = it.now_time - anchor_time;
        last = curve_time[n-1];
        if (elapsed > last) begin
          if (last == 0) fault = 1;
          else elapsed = elapsed % last;
        end
        // Find the first later key and blend from the one before it
        if (!fault) begin
          for (int i = 1; i < n; i++) begin
            if (!found && elapsed < curve_time[i]) begin
              found = 1;
              prev = curve_time[i-1];
              nxt = curve_time[i];
              num = 0;
              den = 1;
              if (elapsed >= prev) begin
                num = 64'(elapsed - prev);
                den = 64'(nxt - prev);
              end
              for (int ch = 0; ch < 4; ch++) begin
                a = curve_chan[i-1][ch];
                b = curve_chan[i][ch];
                col[ch] = (a * (den - num) + b * num) / den;
              end
            end
          end
        end
        // Apply gain and saturate
        for (int ch = 0; ch < 4; ch++) begin
          s = (col[ch] * gain_now) >> 8;
          col[ch] = (s > 65535) ? 65535 : s;
        end
        res = mk_color(16'(col[0]), 16'(col[1]), 16'(col[2]), 16'(col[3]), fault);
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  function automatic void note_miss(string what, out_item_t want, out_item_t got);
    miss_count++;
    if (miss_count <= 10)
      $display("MISMATCH %s: expected r=%h g=%h b=%h a=%h f=%b, got r=%h g=%h b=%h a=%h f=%b",
               what, want.out_red, want.out_green, want.out_blue, want.out_alpha,
               want.time_fault, got.out_red, got.out_green, got.out_blue, got.out_alpha,
               got.time_fault);
  endfunction

  // Track register writes, accepted transactions and results; watch for hangs
  always @(posedge clk_i) begin : monitor_p
    row_tag_t tag;
    out_item_t res, want;
    bit has, moved;
    moved = 0;
    if (rst_ni) begin
      if (cfg_we_i) begin
        moved = 1;
        if (cfg_idx_i == REG_KEYS_IN_USE) key_count = cfg_data_i[4:0];
        else gain_now = cfg_data_i;
      end
      if (in_valid_i && !in_stall_o) begin
        moved = 1;
        tag = row_tags.pop_front();
        has = curve_step(in_i, res);
        if (tag.typed) begin
          has = tag.want_res;
          res = tag.want;
        end
        if (has) pending_colors.push_back(res);
      end
      if (out_valid_o && !out_stall_i) begin
        moved = 1;
        if (pending_colors.size() == 0) begin
          note_miss("unexpected result", '0, out_o);
        end else begin
          want = pending_colors.pop_front();
          if (out_o.out_red !== want.out_red || out_o.out_green !== want.out_green ||
              out_o.out_blue !== want.out_blue || out_o.out_alpha !== want.out_alpha ||
              out_o.time_fault !== want.time_fault)
            note_miss("color", want, out_o);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("keyframe_color_curve_sampler_core regression: fail");
        $finish;
      end
    end
  end

  // Receiver: random stall, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_ask && !hold_done) begin
      out_stall_i <= 1'b1;
      held++;
      if (held >= HOLD_CYCLES) hold_done = 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_pct);
    end
  end

  task automatic send_item(in_item_t it, row_tag_t tag);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    row_tags.push_back(tag);
    in_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Drop valid and wait until the block has gone quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_colors.size() != 0 || row_tags.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(logic [4:0] keys, logic [15:0] gain);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_KEYS_IN_USE;
    cfg_data_i <= 16'(keys);
    @(posedge clk_i);
    cfg_idx_i <= REG_GLOBAL_GAIN;
    cfg_data_i <= gain;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [15:0] rnd_chan();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic send_plain(in_item_t it);
    row_tag_t tag;
    tag = '{default: '0};
    send_item(it, tag);
  endtask

  // Reload all sixteen slots with non-decreasing times
  task automatic rebuild_table();
    logic [31:0] t;
    int pick;
    pick = $urandom_range(0, 3);
    g_max = (pick == 0) ? 4 : (pick == 1) ? 64 : (pick == 2) ? 4096 : (1 << 27);
    t = $urandom_range(0, g_max);
    for (int k = 0; k < 16; k++) begin
      if (k > 0) t += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, g_max);
      g_time[k] = t;
      send_plain(mk_item(CMD_LOAD, 4'(k), t, rnd_chan(), rnd_chan(), rnd_chan(), rnd_chan(),
                         $urandom));
    end
  endtask

  task automatic random_item(output int used);
    int r, k;
    logic [31:0] lo, hi, now, last;
    longint unsigned span;
    r = $urandom_range(0, 99);
    used = 1;
    if (r < 4) begin
      rebuild_table();
      used = 16;
    end else if (r < 14) begin
      k = $urandom_range(0, 15);
      lo = (k > 0) ? g_time[k-1] : 0;
      hi = (k < 15) ? g_time[k+1] : lo + g_max;
      if ($urandom_range(0, 3) == 0 || hi < lo) g_time[k] = $urandom;
      else g_time[k] = $urandom_range(lo, hi);
      send_plain(mk_item(CMD_LOAD, 4'(k), g_time[k], rnd_chan(), rnd_chan(), rnd_chan(),
                         rnd_chan(), $urandom));
    end else if (r < 22) begin
      g_start = $urandom;
      send_plain(mk_item(CMD_RESTART, 4'($urandom), $urandom, rnd_chan(), rnd_chan(),
                         rnd_chan(), rnd_chan(), g_start));
    end else if (r < 25) begin
      send_plain(mk_item(CMD_UNUSED, 4'($urandom), $urandom, rnd_chan(), rnd_chan(),
                         rnd_chan(), rnd_chan(), $urandom));
    end else begin
      last = (g_keys == 0) ? 1000 : g_time[g_keys-1];
      span = 2 * longint'(last) + 2;
      if (span > 32'hFFFFFFFF) span = 32'hFFFFFFFF;
      r = $urandom_range(0, 99);
      if (r < 70) now = g_start + $urandom_range(0, 32'(span));
      else if (r < 85) now = g_start + g_time[$urandom_range(0, 15)];
      else now = $urandom;
      send_plain(mk_item(CMD_SAMPLE, 4'($urandom), $urandom, rnd_chan(), rnd_chan(),
                         rnd_chan(), rnd_chan(), now));
    end
  endtask

  initial begin : stimulus_p
    int phase_keys [NUM_PHASES];
    int phase_gain [NUM_PHASES];
    int used, sent;
    phase_keys = '{16, 1, 8, $urandom_range(2, 16), 16, 0, $urandom_range(1, 16), 2};
    phase_gain = '{256, 65535, 0, $urandom_range(0, 65535), 512, 256, $urandom_range(0, 65535), 1};

    // Directed table: empty table, unused command, zero last time, exact end,
    // wrap, timer rollover, gain extremes, before-first-key clamp
    add_typed(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 5), 0, '0);
    add_item(mk_item(CMD_UNUSED, 4'hF, '1, '1, '1, '1, '1, '1));
    add_item(mk_item(CMD_LOAD, 0, 0, 16'hFFFF, 16'h0000, 16'h1234, 16'h8000, 0));
    add_item(mk_item(CMD_LOAD, 1, 100, 16'h0000, 16'hFFFF, 16'h5678, 16'h8000, 0));
    add_cfg(1, 256);
    add_typed(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 0), 1, mk_color(0, 0, 0, 0, 0));
    add_typed(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 7), 1, mk_color(0, 0, 0, 0, 1));
    add_cfg(2, 256);
    add_typed(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 0), 1,
              mk_color(16'hFFFF, 16'h0000, 16'h1234, 16'h8000, 0));
    add_item(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 50));
    add_typed(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 100), 1, mk_color(0, 0, 0, 0, 0));
    add_item(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 150));
    add_item(mk_item(CMD_RESTART, 0, 0, 0, 0, 0, 0, 32'hFFFFFFF0));
    add_item(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 32'h00000010));
    add_cfg(2, 16'hFFFF);
    add_typed(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 32'hFFFFFFF0), 1,
              mk_color(16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF, 0));
    add_cfg(2, 0);
    add_typed(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 32'h00000000), 1, mk_color(0, 0, 0, 0, 0));
    add_cfg(2, 256);
    add_item(mk_item(CMD_LOAD, 0, 60, 16'hFFFF, 16'h0000, 16'h1234, 16'h8000, 0));
    add_typed(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 32'h00000022), 1,
              mk_color(16'hFFFF, 16'h0000, 16'h1234, 16'h8000, 0));
    add_item(mk_item(CMD_LOAD, 1, '1, '1, '1, '1, '1, 0));
    add_item(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 32'hFFFFFFEE));
    add_item(mk_item(CMD_SAMPLE, 0, 0, 0, 0, 0, 0, 32'hFFFFFFEF));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        settle();
        write_regs(plan[i].keys, plan[i].gain);
      end else begin
        send_item(plan[i].item, plan[i].tag);
      end
    end
    g_start = 32'hFFFFFFF0;

    // Random phases: new register setting and idle pattern for each
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      g_keys = phase_keys[p];
      write_regs(5'(phase_keys[p]), 16'(phase_gain[p]));
      case (p % 4)
        0: begin tx_pct = 0;  rx_pct = 0;  end
        1: begin tx_pct = 59; rx_pct = 0;  end
        2: begin tx_pct = 0;  rx_pct = 59; end
        default: begin tx_pct = 36; rx_pct = 36; end
      endcase
      if (p == 4) hold_ask = 1;
      sent = 0;
      if (p == 0) begin
        rebuild_table();
        sent = 16;
      end
      while (sent < PHASE_ITEMS) begin
        random_item(used);
        sent += used;
      end
    end

    settle();
    if (miss_count == 0 && pending_colors.size() == 0)
      $display("keyframe_color_curve_sampler_core regression: pass");
    else
      $display("keyframe_color_curve_sampler_core regression: fail");
    $finish;
  end

endmodule
